FILE: sv/sac_pkg.sv
// Package for the set-associative cache tag and LRU controller.
// Holds sizes, operation and register codes, and the line and command types.
// No dependencies.
`default_nettype none

package sac_pkg;

   localparam int SETS      = 256;
   localparam int WAYS      = 4;
   localparam int ADDR_BITS = 24;

   localparam int SET_BITS     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_CNT_BITS = $clog2(WAYS + 1);
   localparam int AGE_BITS     = WAY_BITS;
   localparam int TAG_BITS     = ADDR_BITS;

   localparam int CSR_DATA_BITS  = 4;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_BITS_REG = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [3:0] RESET_OFFSET_BITS = 4'd4;
   localparam logic [3:0] RESET_INDEX_BITS  = 4'd6;
   localparam logic [2:0] RESET_WAYS_IN_USE = 3'd4;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic                valid;
      logic [AGE_BITS-1:0] age;
      logic [TAG_BITS-1:0] tag;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

FILE: sv/sac_ctrl.sv
// Controller of the cache tag and LRU block: accept, lookup and result handshake.
// Depends on sac_pkg for the command type.
`default_nettype none

module sac_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sac_pkg::cmd_type      cmd
);
   import sac_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.commit = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_LOOKUP)
      else $error("accepted beat did not start a lookup");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("result appeared without a lookup");

   a_hold_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && rsp_valid_ff && rsp_stall) |=> state_ff == ST_LOOKUP)
      else $error("lookup finished over a pending result");

endmodule

`default_nettype wire

FILE: sv/sac_datapath.sv
// Datapath of the cache tag and LRU block: config registers, line memory,
// hit and victim selection, age update and result registers. Depends on sac_pkg.
`default_nettype none

module sac_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire sac_pkg::cmd_type                       cmd,
   input  wire logic                                   req_operation,
   input  wire logic [sac_pkg::ADDR_BITS-1:0]          req_address,
   input  wire logic                                   csr_write,
   input  wire logic [sac_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [sac_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output logic                                        rsp_hit,
   output logic [1:0]                                  rsp_way,
   output logic                                        rsp_filled
);
   import sac_pkg::*;

   logic [3:0] offset_bits_ff;
   logic [3:0] index_bits_ff;
   logic [2:0] ways_in_use_ff;

   row_type                line_mem [SETS];
   logic [SETS-1:0]        row_valid_ff;
   row_type                rd_row_ff;
   logic                   row_ok_ff;
   logic                   op_ff;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [SET_BITS-1:0]    set_ff, set_in;

   logic                   rsp_hit_ff, rsp_hit_in;
   logic [1:0]             rsp_way_ff, rsp_way_in;
   logic                   rsp_filled_ff, rsp_filled_in;

   logic [4:0]             tag_shift;
   logic [ADDR_BITS-1:0]   idx_field;
   logic [SET_BITS-1:0]    set_mask;

   logic [WAY_CNT_BITS-1:0] n_ways;
   row_type                 row_eff, new_row;
   logic [WAYS-1:0]         in_use, match, invalid;
   logic                    hit, found;
   logic [WAY_BITS-1:0]     hw, victim;
   logic [AGE_BITS-1:0]     ha, oldest;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= RESET_OFFSET_BITS;
         index_bits_ff  <= RESET_INDEX_BITS;
         ways_in_use_ff <= RESET_WAYS_IN_USE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET_BITS:    offset_bits_ff <= csr_data;
            CSR_INDEX_BITS_REG: index_bits_ff  <= csr_data;
            CSR_WAYS_IN_USE:    ways_in_use_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      tag_shift = {1'b0, offset_bits_ff} + {1'b0, index_bits_ff};
      tag_in    = TAG_BITS'(req_address >> tag_shift);
      idx_field = req_address >> offset_bits_ff;
      for (int j = 0; j < SET_BITS; j++) begin
         set_mask[j] = (32'(index_bits_ff) > j);
      end
      set_in = idx_field[SET_BITS-1:0] & set_mask;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_row_ff <= line_mem[set_in];
      end
      if (cmd.commit) begin
         line_mem[set_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.commit) begin
         row_valid_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         row_ok_ff <= row_valid_ff[set_in];
         op_ff     <= req_operation;
         tag_ff    <= tag_in;
         set_ff    <= set_in;
      end
      if (cmd.commit) begin
         rsp_hit_ff    <= rsp_hit_in;
         rsp_way_ff    <= rsp_way_in;
         rsp_filled_ff <= rsp_filled_in;
      end
   end

   always_comb begin
      if (ways_in_use_ff == 3'd0) begin
         n_ways = WAY_CNT_BITS'(1);
      end else if (32'(ways_in_use_ff) > WAYS) begin
         n_ways = WAY_CNT_BITS'(WAYS);
      end else begin
         n_ways = WAY_CNT_BITS'(ways_in_use_ff);
      end

      row_eff = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (!row_ok_ff) begin
            row_eff[w].valid = 1'b0;
            row_eff[w].age   = '0;
         end
         in_use[w]  = (32'(n_ways) > w);
         match[w]   = in_use[w] && row_eff[w].valid && (row_eff[w].tag == tag_ff);
         invalid[w] = in_use[w] && !row_eff[w].valid;
      end

      hit    = 1'b0;
      hw     = '0;
      found  = 1'b0;
      victim = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit = 1'b1;
            hw  = WAY_BITS'(w);
         end
         if (invalid[w]) begin
            found  = 1'b1;
            victim = WAY_BITS'(w);
         end
      end
      ha = row_eff[hw].age;

      oldest = '0;
      if (!found) begin
         for (int w = 0; w < WAYS; w++) begin
            if (in_use[w] && (w == 0 || row_eff[w].age > oldest)) begin
               oldest = row_eff[w].age;
               victim = WAY_BITS'(w);
            end
         end
      end

      new_row = row_eff;
      if (hit) begin
         for (int w = 0; w < WAYS; w++) begin
            if (WAY_BITS'(w) != hw && in_use[w] && row_eff[w].valid && row_eff[w].age < ha) begin
               new_row[w].age = row_eff[w].age + AGE_BITS'(1);
            end
         end
         new_row[hw].age = '0;
      end else if (op_ff == OP_LOAD) begin
         for (int w = 0; w < WAYS; w++) begin
            if (WAY_BITS'(w) != victim && in_use[w] && row_eff[w].valid &&
                32'(row_eff[w].age) < 32'(n_ways) - 1) begin
               new_row[w].age = row_eff[w].age + AGE_BITS'(1);
            end
         end
         new_row[victim].valid = 1'b1;
         new_row[victim].tag   = tag_ff;
         new_row[victim].age   = '0;
      end

      rsp_hit_in    = hit;
      rsp_filled_in = !hit && (op_ff == OP_LOAD);
      if (hit) begin
         rsp_way_in = 2'(hw);
      end else if (op_ff == OP_LOAD) begin
         rsp_way_in = 2'(victim);
      end else begin
         rsp_way_in = 2'd0;
      end
   end

   assign rsp_hit    = rsp_hit_ff;
   assign rsp_way    = rsp_way_ff;
   assign rsp_filled = rsp_filled_ff;

endmodule

`default_nettype wire

FILE: sv/set_assoc_cache_lru_tags_top.sv
// Top level of the set-associative cache tag and LRU controller.
// An accepted request beat reads its set's row into a register; the lookup then
// writes the result registers that drive the response beat, and a stalled pending
// response holds the lookup. No new request is taken until the row is written back.
// Reset clears the controller, the per-set row valid bits and loads the
// config registers with 4, 6 and 4; no clearing pass is needed.
`default_nettype none

module set_assoc_cache_lru_tags_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_operation,
   input  wire logic [sac_pkg::ADDR_BITS-1:0]       req_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [1:0]                               rsp_way,
   output logic                                     rsp_filled,
   input  wire logic                                csr_write,
   input  wire logic [sac_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [sac_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sac_pkg::*;

   cmd_type cmd;

   sac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sac_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req_operation),
      .req_address   (req_address),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_hit       (rsp_hit),
      .rsp_way       (rsp_way),
      .rsp_filled    (rsp_filled)
   );

endmodule

`default_nettype wire

FILE: dv/set_assoc_cache_lru_tags_top_tb.sv
// Testbench for set_assoc_cache_lru_tags_top: directed and random loads and stores,
// checked beat by beat against a tag, valid and age predictor kept in this file.
// Depends on sac_pkg and the top level only.
`default_nettype none

module set_assoc_cache_lru_tags_top_tb;
   import sac_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 150;
   localparam int QUIET_PHASE = 2;
   localparam int IDLE_PCT = 28;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic       hit;
      logic [1:0] way;
      logic       filled;
   } lookup_t;

   typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_t;

   typedef struct packed {
      row_kind_t                 kind;
      logic                      op;
      logic [ADDR_BITS-1:0]      addr;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  reg_value;
      logic                      pin;
      lookup_t                   want;
   } plan_row_t;

   localparam plan_row_t DIRECTED_PLAN [37] = '{
      '{ROW_ACCESS, OP_LOAD,  24'h000000, '0, '0, 1'b1, '{1'b0, 2'd0, 1'b1}},
      '{ROW_ACCESS, OP_LOAD,  24'h000000, '0, '0, 1'b1, '{1'b1, 2'd0, 1'b0}},
      '{ROW_ACCESS, OP_STORE, 24'hFFFFFF, '0, '0, 1'b1, '{1'b0, 2'd0, 1'b0}},
      '{ROW_ACCESS, OP_LOAD,  24'hFFFFFF, '0, '0, 1'b1, '{1'b0, 2'd0, 1'b1}},
      '{ROW_ACCESS, OP_STORE, 24'hFFFFFF, '0, '0, 1'b1, '{1'b1, 2'd0, 1'b0}},
      '{ROW_ACCESS, OP_LOAD,  24'h000400, '0, '0, 1'b1, '{1'b0, 2'd1, 1'b1}},
      '{ROW_ACCESS, OP_LOAD,  24'h000800, '0, '0, 1'b1, '{1'b0, 2'd2, 1'b1}},
      '{ROW_ACCESS, OP_LOAD,  24'h000C00, '0, '0, 1'b1, '{1'b0, 2'd3, 1'b1}},
      '{ROW_ACCESS, OP_LOAD,  24'h001000, '0, '0, 1'b0, '0},
      '{ROW_ACCESS, OP_STORE, 24'h000400, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd0, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000C00, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd7, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000800, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_OFFSET_BITS, 4'd0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_INDEX_BITS_REG, 4'd8, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd4, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000755, '0, '0, 1'b1, '{1'b0, 2'd0, 1'b1}},
      '{ROW_ACCESS, OP_LOAD,  24'h010055, '0, '0, 1'b1, '{1'b0, 2'd1, 1'b1}},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd1, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h010055, '0, '0, 1'b1, '{1'b0, 2'd0, 1'b1}},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd5, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h010055, '0, '0, 1'b1, '{1'b1, 2'd0, 1'b0}},
      '{ROW_ACCESS, OP_LOAD,  24'h000166, '0, '0, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000266, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd1, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000366, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd2, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000466, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_WAYS_IN_USE, 4'd4, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_INDEX_BITS_REG, 4'd15, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_OFFSET_BITS, 4'd15, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h123456, '0, '0, 1'b0, '0},
      '{ROW_ACCESS, OP_STORE, 24'hFFFFFF, '0, '0, 1'b0, '0},
      '{ROW_WRITE,  OP_LOAD,  24'h000000, CSR_UNMAPPED, 4'd15, 1'b0, '0},
      '{ROW_ACCESS, OP_LOAD,  24'h000000, '0, '0, 1'b0, '0}
   };

   localparam int PHASE_OFFSET [8] = '{4, 0, 12, 15, 0, 3, 12, 5};
   localparam int PHASE_INDEX  [8] = '{6, 0, 8, 15, 8, 2, 0, 10};
   localparam int PHASE_WAYS   [8] = '{4, 1, 4, 7, 2, 3, 0, 6};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = OP_LOAD;
   logic [ADDR_BITS-1:0] req_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [1:0] rsp_way;
   logic rsp_filled;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic req_pinned = 1'b0;
   lookup_t req_pinned_res = '0;

   logic [TAG_BITS-1:0] tag_store [SETS][WAYS];
   logic valid_store [SETS][WAYS];
   logic [AGE_BITS-1:0] age_store [SETS][WAYS];
   int unsigned cfg_offset_bits;
   int unsigned cfg_index_bits;
   int unsigned cfg_ways;

   lookup_t due_lookups [$];
   int idle_pct = IDLE_PCT;
   int stuck_cycles = 0;
   int mismatches = 0;
   int hits_seen = 0;
   int fills_seen = 0;
   int beats_checked = 0;

   set_assoc_cache_lru_tags_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_way       (rsp_way),
      .rsp_filled    (rsp_filled),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #1 clock = ~clock;

   function automatic lookup_t tag_lookup(input logic op, input logic [ADDR_BITS-1:0] addr);
      lookup_t res;
      int n, s, w, hw, victim;
      logic [31:0] wide, field, shifted;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_BITS-1:0] hit_age, oldest;
      bit found;
      n = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS) ? WAYS : int'(cfg_ways);
      wide = 32'(addr);
      field = (wide >> cfg_offset_bits) & ((32'd1 << cfg_index_bits) - 32'd1);
      s = int'(field % SETS);
      shifted = wide >> (cfg_offset_bits + cfg_index_bits);
      tag = shifted[TAG_BITS-1:0];
      res = '0;
      found = 1'b0;
      hw = 0;
      for (w = 0; w < n; w++) begin
         if (!found && valid_store[s][w] && tag_store[s][w] == tag) begin
            found = 1'b1;
            hw = w;
         end
      end
      if (found) begin
         hit_age = age_store[s][hw];
         for (w = 0; w < n; w++) begin
            if (w != hw && valid_store[s][w] && age_store[s][w] < hit_age)
               age_store[s][w] = age_store[s][w] + 1'b1;
         end
         age_store[s][hw] = '0;
         res.hit = 1'b1;
         res.way = 2'(hw);
         return res;
      end
      if (op == OP_STORE)
         return res;
      victim = 0;
      for (w = n - 1; w >= 0; w--) begin
         if (!valid_store[s][w]) begin
            victim = w;
            found = 1'b1;
         end
      end
      if (!found) begin
         oldest = age_store[s][0];
         for (w = 1; w < n; w++) begin
            if (age_store[s][w] > oldest) begin
               oldest = age_store[s][w];
               victim = w;
            end
         end
      end
      for (w = 0; w < n; w++) begin
         if (w != victim && valid_store[s][w] && int'(age_store[s][w]) < n - 1)
            age_store[s][w] = age_store[s][w] + 1'b1;
      end
      valid_store[s][victim] = 1'b1;
      tag_store[s][victim] = tag;
      age_store[s][victim] = '0;
      res.way = 2'(victim);
      res.filled = 1'b1;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [1:0] want,
                                         input logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      lookup_t want;
      lookup_t got;
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               valid_store[s][w] = 1'b0;
               age_store[s][w] = '0;
            end
         end
         cfg_offset_bits = RESET_OFFSET_BITS;
         cfg_index_bits = RESET_INDEX_BITS;
         cfg_ways = RESET_WAYS_IN_USE;
         stuck_cycles = 0;
         rsp_stall <= 1'b0;
      end else begin
         stuck_cycles++;
         if (csr_write) begin
            case (csr_index)
               CSR_OFFSET_BITS:    cfg_offset_bits = csr_data;
               CSR_INDEX_BITS_REG: cfg_index_bits = csr_data;
               CSR_WAYS_IN_USE:    cfg_ways = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            stuck_cycles = 0;
            got = tag_lookup(req_operation, req_address);
            due_lookups.push_back(req_pinned ? req_pinned_res : got);
         end
         if (rsp_valid && !rsp_stall) begin
            stuck_cycles = 0;
            beats_checked++;
            hits_seen += rsp_hit;
            fills_seen += rsp_filled;
            if (due_lookups.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, got hit %0b way %0d filled %0b",
                        $time, rsp_hit, rsp_way, rsp_filled);
               mismatches++;
            end else begin
               want = due_lookups.pop_front();
               compare_field("hit", 2'(want.hit), 2'(rsp_hit));
               compare_field("way", want.way, rsp_way);
               compare_field("filled", 2'(want.filled), 2'(rsp_filled));
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] addr,
                              input logic pin, input lookup_t want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_pinned <= pin;
      req_pinned_res <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int directed_beats;
      int random_beats;
      int off, idx, ways, base_set, set_bits;
      logic [31:0] wide;
      logic op;
      directed_beats = 0;
      random_beats = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[r]) begin
         if (DIRECTED_PLAN[r].kind == ROW_WRITE) begin
            write_csr(DIRECTED_PLAN[r].reg_index, DIRECTED_PLAN[r].reg_value);
         end else begin
            send_access(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].addr,
                        DIRECTED_PLAN[r].pin, DIRECTED_PLAN[r].want);
            directed_beats++;
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 8) begin
            off = PHASE_OFFSET[phase];
            idx = PHASE_INDEX[phase];
            ways = PHASE_WAYS[phase];
         end else begin
            off = $urandom_range(0, 15);
            idx = $urandom_range(0, 15);
            ways = $urandom_range(0, 7);
         end
         write_csr(CSR_OFFSET_BITS, 4'(off));
         write_csr(CSR_INDEX_BITS_REG, 4'(idx));
         write_csr(CSR_WAYS_IN_USE, 4'(ways));
         idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
         base_set = $urandom_range(0, 255);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 10) begin
               wide = $urandom;
            end else begin
               set_bits = (base_set + $urandom_range(0, 2)) & ((1 << idx) - 1);
               wide = (32'($urandom_range(0, 6)) << (off + idx))
                      | (32'(set_bits) << off)
                      | ($urandom & ((32'd1 << off) - 32'd1));
            end
            op = ($urandom_range(99) < 30) ? OP_STORE : OP_LOAD;
            send_access(op, wide[ADDR_BITS-1:0], 1'b0, '0);
            random_beats++;
         end
      end
      idle_pct = IDLE_PCT;

      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d directed and %0d random accesses over %0d register settings",
               directed_beats, random_beats, PHASES);
      $display("Checked %0d response beats: %0d hits, %0d line fills, %0d mismatches",
               beats_checked, hits_seen, fills_seen, mismatches);
      if (mismatches == 0 && due_lookups.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
sv/sac_pkg.sv
sv/sac_ctrl.sv
sv/sac_datapath.sv
sv/set_assoc_cache_lru_tags_top.sv
dv/set_assoc_cache_lru_tags_top_tb.sv
